>>> hdl/lbl_pkg.sv
// Shared types and constants for the Lorentz boost to lab frame unit.
`timescale 1ns / 1ps
`default_nettype none

package lbl_pkg;

    localparam int DIGIT_BITS = 24;

    typedef struct packed {
        logic bad;
        logic rest;
    } t_flags;

endpackage

`default_nettype wire

>>> hdl/lbl_if.sv
// Valid/ready stream interfaces for the input and result transactions.
`timescale 1ns / 1ps
`default_nettype none

interface lbl_in_if #(parameter int WORD_BITS = 48);
    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] parent_px;
    logic signed [WORD_BITS-1:0] parent_py;
    logic signed [WORD_BITS-1:0] parent_pz;
    logic signed [WORD_BITS-1:0] parent_energy;
    logic signed [WORD_BITS-1:0] daughter_px;
    logic signed [WORD_BITS-1:0] daughter_py;
    logic signed [WORD_BITS-1:0] daughter_pz;
    logic signed [WORD_BITS-1:0] daughter_energy;

    modport source (
        output valid, parent_px, parent_py, parent_pz, parent_energy,
               daughter_px, daughter_py, daughter_pz, daughter_energy,
        input  ready
    );
    modport sink (
        input  valid, parent_px, parent_py, parent_pz, parent_energy,
               daughter_px, daughter_py, daughter_pz, daughter_energy,
        output ready
    );
endinterface

interface lbl_out_if #(parameter int WORD_BITS = 48);
    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] lab_px;
    logic signed [WORD_BITS-1:0] lab_py;
    logic signed [WORD_BITS-1:0] lab_pz;
    logic signed [WORD_BITS-1:0] lab_energy;
    logic                        bad_parent;

    modport source (
        output valid, lab_px, lab_py, lab_pz, lab_energy, bad_parent,
        input  ready
    );
    modport sink (
        input  valid, lab_px, lab_py, lab_pz, lab_energy, bad_parent,
        output ready
    );
endinterface

`default_nettype wire

>>> hdl/lbl_delay.sv
// Enabled shift-register delay line for data travelling beside the pipeline.
`timescale 1ns / 1ps
`default_nettype none

module lbl_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [WIDTH-1:0] i_d,
    output logic      [WIDTH-1:0] o_d
);

    logic [WIDTH-1:0] r_pipe [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pipe[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_pipe[k] <= r_pipe[k-1];
            end
        end
    end

    assign o_d = r_pipe[DEPTH-1];

endmodule

`default_nettype wire

>>> hdl/lbl_mul.sv
// Pipelined unsigned multiplier, one digit of the second operand per stage.
`timescale 1ns / 1ps
`default_nettype none

module lbl_mul import lbl_pkg::*; #(
    parameter int AW = 48,
    parameter int BW = 48
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [AW-1:0]    i_a,
    input  wire logic [BW-1:0]    i_b,
    output logic      [AW+BW-1:0] o_p
);

    localparam int D  = DIGIT_BITS;
    localparam int NA = (AW + D - 1) / D;
    localparam int NB = (BW + D - 1) / D;
    localparam int AP = NA * D;
    localparam int BP = NB * D;
    localparam int XW = AP + BP;
    localparam int RW = AP + D;

    logic [AP-1:0] r_a   [NB-1];
    logic [BP-1:0] r_b   [NB-1];
    logic [XW-1:0] r_acc [NB];
    logic [AP-1:0] a_in  [NB];
    logic [BP-1:0] b_in  [NB];
    logic [XW-1:0] acc_in [NB];

    genvar s;
    generate
        for (s = 0; s < NB; s++) begin : g_step
            logic [RW-1:0] n_row;
            logic [XW-1:0] n_acc;

            if (s == 0) begin : g_first
                assign a_in[s]   = AP'(i_a);
                assign b_in[s]   = BP'(i_b);
                assign acc_in[s] = '0;
            end else begin : g_next
                assign a_in[s]   = r_a[s-1];
                assign b_in[s]   = r_b[s-1];
                assign acc_in[s] = r_acc[s-1];
            end

            always_comb begin
                n_row = '0;
                for (int i = 0; i < NA; i++) begin
                    n_row = n_row + (RW'((2*D)'(a_in[s][i*D +: D]) *
                                         (2*D)'(b_in[s][s*D +: D])) << (i*D));
                end
                n_acc = acc_in[s] + (XW'(n_row) << (s*D));
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_acc[s] <= n_acc;
                end
            end

            if (s < NB - 1) begin : g_keep
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_a[s] <= a_in[s];
                        r_b[s] <= b_in[s];
                    end
                end
            end
        end
    endgenerate

    assign o_p = r_acc[NB-1][AW+BW-1:0];

endmodule

`default_nettype wire

>>> hdl/lbl_sqrt.sv
// Pipelined floor square root, one root bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module lbl_sqrt #(
    parameter int RW = 48
) (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [2*RW-1:0]   i_x,
    output logic      [RW-1:0]     o_root
);

    localparam int XW = 2 * RW;
    localparam int MW = RW + 3;

    logic [XW-1:0] r_x    [RW-1];
    logic [MW-1:0] r_rem  [RW-1];
    logic [RW-1:0] r_root [RW];
    logic [XW-1:0] x_in    [RW];
    logic [MW-1:0] rem_in  [RW];
    logic [RW-1:0] root_in [RW];

    genvar s;
    generate
        for (s = 0; s < RW; s++) begin : g_step
            logic [MW-1:0] n_sh;
            logic [MW-1:0] n_trial;
            logic          n_ge;

            if (s == 0) begin : g_first
                assign x_in[s]    = i_x;
                assign rem_in[s]  = '0;
                assign root_in[s] = '0;
            end else begin : g_next
                assign x_in[s]    = r_x[s-1];
                assign rem_in[s]  = r_rem[s-1];
                assign root_in[s] = r_root[s-1];
            end

            always_comb begin
                n_sh    = {rem_in[s][MW-3:0], x_in[s][XW-1:XW-2]};
                n_trial = MW'({root_in[s], 2'b01});
                n_ge    = (n_sh >= n_trial);
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_root[s] <= {root_in[s][RW-2:0], n_ge};
                end
            end

            if (s < RW - 1) begin : g_keep
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_x[s]   <= x_in[s] << 2;
                        r_rem[s] <= n_ge ? (n_sh - n_trial) : n_sh;
                    end
                end
            end
        end
    endgenerate

    assign o_root = r_root[RW-1];

endmodule

`default_nettype wire

>>> hdl/lbl_div.sv
// Pipelined restoring divider with an overflow check, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module lbl_div #(
    parameter int NW = 146,
    parameter int DW = 97,
    parameter int QW = 50
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    input  wire logic          i_neg,
    output logic      [QW-1:0] o_q,
    output logic               o_ovf,
    output logic               o_neg
);

    localparam int CW = (NW > DW + QW) ? NW : DW + QW;

    logic [NW-1:0] r_num0;
    logic [DW-1:0] r_den0;
    logic          r_neg0;
    logic          r_ovf0;

    logic [NW-1:0] r_rem [QW-1];
    logic [DW-1:0] r_den [QW-1];
    logic [QW-1:0] r_q   [QW];
    logic          r_ovf [QW];
    logic          r_neg [QW];

    logic [NW-1:0] rem_in [QW];
    logic [DW-1:0] den_in [QW];
    logic [QW-1:0] q_in   [QW];
    logic          ovf_in [QW];
    logic          neg_in [QW];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num0 <= i_num;
            r_den0 <= i_den;
            r_neg0 <= i_neg;
            r_ovf0 <= (CW'(i_num) >= (CW'(i_den) << QW));
        end
    end

    genvar s;
    generate
        for (s = 0; s < QW; s++) begin : g_step
            logic [CW-1:0] n_sh;
            logic          n_ge;

            if (s == 0) begin : g_first
                assign rem_in[s] = r_num0;
                assign den_in[s] = r_den0;
                assign q_in[s]   = '0;
                assign ovf_in[s] = r_ovf0;
                assign neg_in[s] = r_neg0;
            end else begin : g_next
                assign rem_in[s] = r_rem[s-1];
                assign den_in[s] = r_den[s-1];
                assign q_in[s]   = r_q[s-1];
                assign ovf_in[s] = r_ovf[s-1];
                assign neg_in[s] = r_neg[s-1];
            end

            always_comb begin
                n_sh = CW'(den_in[s]) << (QW - 1 - s);
                n_ge = (CW'(rem_in[s]) >= n_sh);
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_q[s]   <= q_in[s] | (QW'(n_ge) << (QW - 1 - s));
                    r_ovf[s] <= ovf_in[s];
                    r_neg[s] <= neg_in[s];
                end
            end

            if (s < QW - 1) begin : g_keep
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_rem[s] <= n_ge ? NW'(CW'(rem_in[s]) - n_sh) : rem_in[s];
                        r_den[s] <= den_in[s];
                    end
                end
            end
        end
    endgenerate

    assign o_q   = r_q[QW-1];
    assign o_ovf = r_ovf[QW-1];
    assign o_neg = r_neg[QW-1];

endmodule

`default_nettype wire

>>> hdl/lorentz_boost_to_lab_unit.sv
// Boosts a daughter four-momentum from its parent's rest frame into the lab frame.
// Throughput: one transaction per cycle; a stalled output holds the whole pipeline.
// Depth is set mostly by the square root and the dividers, which resolve one bit per stage.
// Reset is synchronous and active low and clears only the stage valid bits.
`timescale 1ns / 1ps
`default_nettype none

module lorentz_boost_to_lab_unit import lbl_pkg::*; #(
    parameter int WORD_BITS = 48
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lbl_in_if.sink    i_in,
    lbl_out_if.source o_out
);

    localparam int W    = WORD_BITS;
    localparam int D    = DIGIT_BITS;
    localparam int L1   = (W + D - 1) / D;
    localparam int L2   = (W + 1 + D - 1) / D;
    localparam int L3   = (2 * W + 1 + D - 1) / D;
    localparam int QW   = W + 2;
    localparam int EW   = 2 * W + 3;
    localparam int RAWW = 8 * W;
    localparam int PNW  = 3 * W + 2;
    localparam int ENW  = 2 * W + 2;
    localparam int NST  = W + QW + L1 + L2 + L3 + 7;

    localparam int F_PE = 3;
    localparam int F_DX = 4;
    localparam int F_DE = 7;

    function automatic logic [W-1:0] fld(input logic [RAWW-1:0] r, input int f);
        return r[f*W +: W];
    endfunction

    function automatic logic neg_of(input logic [RAWW-1:0] r, input int f);
        return r[f*W + W - 1];
    endfunction

    function automatic logic [W-1:0] mag(input logic [W-1:0] x);
        return x[W-1] ? W'(-x) : x;
    endfunction

    function automatic logic signed [EW-1:0] apply_sign(input logic [EW-1:0] m,
                                                        input logic neg);
        return neg ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [QW+1:0] signed_q(input logic [QW-1:0] q,
                                                      input logic neg);
        logic signed [QW+1:0] t;
        t = $signed((QW+2)'(q));
        return neg ? -t : t;
    endfunction

    function automatic logic [W-1:0] clamp(input logic signed [QW+1:0] v,
                                           input logic ovf, input logic neg);
        logic signed [QW+1:0] hi;
        logic signed [QW+1:0] lo;
        logic [W-1:0]         res;
        hi = (QW+2)'($signed({1'b0, {(W-1){1'b1}}}));
        lo = (QW+2)'($signed({1'b1, {(W-1){1'b0}}}));
        priority if (ovf) begin
            res = neg ? lo[W-1:0] : hi[W-1:0];
        end else if (v > hi) begin
            res = hi[W-1:0];
        end else if (v < lo) begin
            res = lo[W-1:0];
        end else begin
            res = v[W-1:0];
        end
        return res;
    endfunction

    logic adv;
    logic [NST-1:0] r_vld;

    assign adv        = !r_vld[NST-1] || o_out.ready;
    assign i_in.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NST-2:0], i_in.valid};
        end
    end

    // Input register.
    logic [RAWW-1:0] r_raw;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_raw <= {i_in.daughter_energy, i_in.daughter_pz, i_in.daughter_py,
                      i_in.daughter_px, i_in.parent_energy, i_in.parent_pz,
                      i_in.parent_py, i_in.parent_px};
        end
    end

    // Squares, dot-product terms and the energy product.
    logic [W-1:0]   m1_a [8];
    logic [W-1:0]   m1_b [8];
    logic [2*W-1:0] m1_p [8];

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            m1_a[j] = mag(fld(r_raw, j));
            m1_b[j] = mag(fld(r_raw, j));
        end
        for (int j = 4; j < 7; j++) begin
            m1_a[j] = mag(fld(r_raw, j));
            m1_b[j] = mag(fld(r_raw, j - 4));
        end
        m1_a[7] = mag(fld(r_raw, F_DE));
        m1_b[7] = mag(fld(r_raw, F_PE));
    end

    genvar j;
    generate
        for (j = 0; j < 8; j++) begin : g_mul1
            lbl_mul #(.AW(W), .BW(W)) u_mul (
                .i_clk (i_clk),
                .i_en  (adv),
                .i_a   (m1_a[j]),
                .i_b   (m1_b[j]),
                .o_p   (m1_p[j])
            );
        end
    endgenerate

    logic [RAWW-1:0] raw1;
    lbl_delay #(.WIDTH(RAWW), .DEPTH(L1)) u_dly_raw1 (
        .i_clk (i_clk), .i_en (adv), .i_d (r_raw), .o_d (raw1)
    );

    // Mass squared, dot product and energy numerator.
    logic [2*W+1:0]        n_psum;
    logic signed [EW-1:0]  n_m2s;
    logic signed [EW-1:0]  n_dp;
    logic signed [EW-1:0]  n_en;
    t_flags                n_flags;
    logic [2*W-1:0]        r_m2;
    logic signed [EW-1:0]  r_dp;
    logic signed [EW-1:0]  r_en;
    t_flags                r_flags;

    always_comb begin
        n_psum = (2*W+2)'(m1_p[0]) + (2*W+2)'(m1_p[1]) + (2*W+2)'(m1_p[2]);
        n_m2s  = $signed(EW'(m1_p[3])) - $signed(EW'(n_psum));
        n_dp   = apply_sign(EW'(m1_p[4]), neg_of(raw1, 4) ^ neg_of(raw1, 0))
               + apply_sign(EW'(m1_p[5]), neg_of(raw1, 5) ^ neg_of(raw1, 1))
               + apply_sign(EW'(m1_p[6]), neg_of(raw1, 6) ^ neg_of(raw1, 2));
        n_en   = n_dp + apply_sign(EW'(m1_p[7]), neg_of(raw1, F_DE));
        n_flags.bad  = n_m2s[EW-1] || (n_m2s == '0);
        n_flags.rest = (fld(raw1, 0) == '0) && (fld(raw1, 1) == '0) &&
                       (fld(raw1, 2) == '0);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_m2    <= n_flags.bad ? '0 : n_m2s[2*W-1:0];
            r_dp    <= n_dp;
            r_en    <= n_en;
            r_flags <= n_flags;
        end
    end

    // Parent mass.
    logic [W-1:0] m3;
    lbl_sqrt #(.RW(W)) u_sqrt (
        .i_clk (i_clk), .i_en (adv), .i_x (r_m2), .o_root (m3)
    );

    logic [RAWW-1:0] raw3;
    lbl_delay #(.WIDTH(RAWW), .DEPTH(1 + W)) u_dly_raw3 (
        .i_clk (i_clk), .i_en (adv), .i_d (raw1), .o_d (raw3)
    );

    logic [W:0]   r_s;
    logic [W-1:0] r_m4;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s  <= (W+1)'(mag(fld(raw3, F_PE))) + (W+1)'(m3);
            r_m4 <= m3;
        end
    end

    logic [RAWW-1:0] raw4;
    lbl_delay #(.WIDTH(RAWW), .DEPTH(1)) u_dly_raw4 (
        .i_clk (i_clk), .i_en (adv), .i_d (raw3), .o_d (raw4)
    );

    logic [2*W:0] des5;
    logic [2*W:0] den5;

    lbl_mul #(.AW(W), .BW(W + 1)) u_mul_des (
        .i_clk (i_clk), .i_en (adv), .i_a (mag(fld(raw4, F_DE))), .i_b (r_s), .o_p (des5)
    );

    lbl_mul #(.AW(W), .BW(W + 1)) u_mul_den (
        .i_clk (i_clk), .i_en (adv), .i_a (r_m4), .i_b (r_s), .o_p (den5)
    );

    logic [RAWW-1:0] raw5;
    lbl_delay #(.WIDTH(RAWW), .DEPTH(L2)) u_dly_raw5 (
        .i_clk (i_clk), .i_en (adv), .i_d (raw4), .o_d (raw5)
    );

    logic [EW-1:0] dp5;
    lbl_delay #(.WIDTH(EW), .DEPTH(W + 1 + L2)) u_dly_dp (
        .i_clk (i_clk), .i_en (adv), .i_d (r_dp), .o_d (dp5)
    );

    // Boost coefficient numerator.
    logic signed [EW-1:0] n_k;
    logic signed [EW-1:0] n_kabs;
    logic [2*W:0]         r_kmag;
    logic                 r_kneg;
    logic [2*W:0]         r_den6;

    always_comb begin
        n_k    = $signed(dp5) + apply_sign(EW'(des5), neg_of(raw5, F_DE));
        n_kabs = n_k[EW-1] ? -n_k : n_k;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_kmag <= n_kabs[2*W:0];
            r_kneg <= n_k[EW-1];
            r_den6 <= den5;
        end
    end

    logic [RAWW-1:0] raw6;
    lbl_delay #(.WIDTH(RAWW), .DEPTH(1)) u_dly_raw6 (
        .i_clk (i_clk), .i_en (adv), .i_d (raw5), .o_d (raw6)
    );

    logic [3*W:0] pk7 [3];

    generate
        for (j = 0; j < 3; j++) begin : g_mul3
            lbl_mul #(.AW(W), .BW(2 * W + 1)) u_mul (
                .i_clk (i_clk),
                .i_en  (adv),
                .i_a   (mag(fld(raw6, j))),
                .i_b   (r_kmag),
                .o_p   (pk7[j])
            );
        end
    endgenerate

    logic [RAWW-1:0] raw7;
    lbl_delay #(.WIDTH(RAWW), .DEPTH(L3)) u_dly_raw7 (
        .i_clk (i_clk), .i_en (adv), .i_d (raw6), .o_d (raw7)
    );

    logic [2*W+1:0] kd7;
    lbl_delay #(.WIDTH(2 * W + 2), .DEPTH(L3)) u_dly_kd (
        .i_clk (i_clk), .i_en (adv), .i_d ({r_kneg, r_den6}), .o_d (kd7)
    );

    logic [EW-1:0] en7;
    lbl_delay #(.WIDTH(EW), .DEPTH(W + 2 + L2 + L3)) u_dly_en (
        .i_clk (i_clk), .i_en (adv), .i_d (r_en), .o_d (en7)
    );

    logic [W-1:0] m7;
    lbl_delay #(.WIDTH(W), .DEPTH(L2 + 1 + L3)) u_dly_m (
        .i_clk (i_clk), .i_en (adv), .i_d (r_m4), .o_d (m7)
    );

    // Rounded numerators for the dividers.
    logic [EW-1:0]  n_eabs;
    logic [PNW-1:0] r_pnum [3];
    logic           r_pneg [3];
    logic [2*W:0]   r_den8;
    logic [ENW-1:0] r_enum;
    logic           r_eneg;
    logic [W-1:0]   r_m8;

    assign n_eabs = en7[EW-1] ? EW'(-en7) : en7;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                r_pnum[i] <= PNW'(pk7[i]) + PNW'(kd7[2*W:0] >> 1);
                r_pneg[i] <= neg_of(raw7, i) ^ kd7[2*W+1];
            end
            r_den8 <= kd7[2*W:0];
            r_enum <= ENW'(n_eabs[2*W:0]) + ENW'(m7 >> 1);
            r_eneg <= en7[EW-1];
            r_m8   <= m7;
        end
    end

    logic [QW-1:0] q9   [4];
    logic          ovf9 [4];
    logic          neg9 [4];

    generate
        for (j = 0; j < 3; j++) begin : g_divp
            lbl_div #(.NW(PNW), .DW(2 * W + 1), .QW(QW)) u_div (
                .i_clk (i_clk),
                .i_en  (adv),
                .i_num (r_pnum[j]),
                .i_den (r_den8),
                .i_neg (r_pneg[j]),
                .o_q   (q9[j]),
                .o_ovf (ovf9[j]),
                .o_neg (neg9[j])
            );
        end
    endgenerate

    lbl_div #(.NW(ENW), .DW(W), .QW(QW)) u_div_e (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_num (r_enum),
        .i_den (r_m8),
        .i_neg (r_eneg),
        .o_q   (q9[3]),
        .o_ovf (ovf9[3]),
        .o_neg (neg9[3])
    );

    logic [RAWW-1:0] raw9;
    lbl_delay #(.WIDTH(RAWW), .DEPTH(QW + 2)) u_dly_raw9 (
        .i_clk (i_clk), .i_en (adv), .i_d (raw7), .o_d (raw9)
    );

    t_flags flags9;
    lbl_delay #(.WIDTH($bits(t_flags)), .DEPTH(W + L2 + L3 + QW + 4)) u_dly_flags (
        .i_clk (i_clk), .i_en (adv), .i_d (r_flags), .o_d (flags9)
    );

    // Final sum, saturation and special cases.
    logic [W-1:0] n_lab [4];
    logic [W-1:0] r_lab [4];
    logic         r_bad;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (flags9.bad) begin
                n_lab[i] = '0;
            end else if (flags9.rest) begin
                n_lab[i] = fld(raw9, F_DX + i);
            end else begin
                n_lab[i] = clamp((QW+2)'($signed(fld(raw9, F_DX + i)))
                                 + signed_q(q9[i], neg9[i]), ovf9[i], neg9[i]);
            end
        end
        if (flags9.bad) begin
            n_lab[3] = '0;
        end else if (flags9.rest) begin
            n_lab[3] = fld(raw9, F_DE);
        end else begin
            n_lab[3] = clamp(signed_q(q9[3], neg9[3]), ovf9[3], neg9[3]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 4; i++) begin
                r_lab[i] <= n_lab[i];
            end
            r_bad <= flags9.bad;
        end
    end

    assign o_out.valid      = r_vld[NST-1];
    assign o_out.lab_px     = r_lab[0];
    assign o_out.lab_py     = r_lab[1];
    assign o_out.lab_pz     = r_lab[2];
    assign o_out.lab_energy = r_lab[3];
    assign o_out.bad_parent = r_bad;

`ifndef ASSERT_OFF
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.bad_parent |->
            (o_out.lab_px == '0) && (o_out.lab_py == '0) &&
            (o_out.lab_pz == '0) && (o_out.lab_energy == '0))
        else $error("Bad parent transaction carries non-zero momentum.");

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |-> !i_in.ready)
        else $error("Input taken while the full pipeline is stalled.");

    a_take_tracked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_vld[0])
        else $error("Accepted transaction lost its valid bit.");
`endif

endmodule

`default_nettype wire

>>> verif/lorentz_boost_to_lab_unit_checker.sv
// Checker that predicts each boosted daughter and compares it with the unit's results.
`timescale 1ns / 1ps

module lorentz_boost_to_lab_unit_checker #(
    parameter int WORD_BITS = 48
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    lbl_in_if.sink                i_in,
    lbl_out_if.sink               i_out,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef logic signed [255:0] t_wide;

    typedef struct packed {
        logic [WORD_BITS-1:0] px;
        logic [WORD_BITS-1:0] py;
        logic [WORD_BITS-1:0] pz;
        logic [WORD_BITS-1:0] energy;
        logic                 bad;
    } t_lab;

    t_lab lab_queue[$];
    int   mismatches;
    int   pending_count;

    function automatic t_wide sign_wide(logic [WORD_BITS-1:0] v);
        logic signed [WORD_BITS-1:0] s;
        s = v;
        return t_wide'(s);
    endfunction

    function automatic t_wide round_div(t_wide num, t_wide den);
        t_wide mag;
        t_wide q;
        mag = (num < 0) ? -num : num;
        q = (mag + (den >>> 1)) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic t_wide floor_sqrt(t_wide a);
        t_wide r;
        t_wide t;
        r = 0;
        for (int k = 64; k >= 0; k--) begin
            t = r | (t_wide'(1) << k);
            if (t * t <= a) r = t;
        end
        return r;
    endfunction

    function automatic logic [WORD_BITS-1:0] clamp_word(t_wide x);
        t_wide hi;
        t_wide lo;
        hi = (t_wide'(1) <<< (WORD_BITS - 1)) - 1;
        lo = -(t_wide'(1) <<< (WORD_BITS - 1));
        if (x > hi) return hi[WORD_BITS-1:0];
        if (x < lo) return lo[WORD_BITS-1:0];
        return x[WORD_BITS-1:0];
    endfunction

    function automatic t_lab boost_to_lab(logic [WORD_BITS-1:0] ppx, logic [WORD_BITS-1:0] ppy,
                                          logic [WORD_BITS-1:0] ppz, logic [WORD_BITS-1:0] pe,
                                          logic [WORD_BITS-1:0] dpx, logic [WORD_BITS-1:0] dpy,
                                          logic [WORD_BITS-1:0] dpz, logic [WORD_BITS-1:0] de);
        t_wide p[3];
        t_wide d[3];
        t_wide e;
        t_wide dew;
        t_wide mass_sq;
        t_wide mass;
        t_wide abs_e;
        t_wide sum;
        t_wide dot;
        t_wide kfac;
        t_wide den;
        t_wide lab[4];
        t_lab  r;
        p[0] = sign_wide(ppx); p[1] = sign_wide(ppy); p[2] = sign_wide(ppz);
        d[0] = sign_wide(dpx); d[1] = sign_wide(dpy); d[2] = sign_wide(dpz);
        e = sign_wide(pe);
        dew = sign_wide(de);
        mass_sq = e * e - p[0] * p[0] - p[1] * p[1] - p[2] * p[2];
        r = '0;
        if (mass_sq <= 0) begin
            r.bad = 1'b1;
            return r;
        end
        if (p[0] == 0 && p[1] == 0 && p[2] == 0) begin
            r.px = dpx; r.py = dpy; r.pz = dpz; r.energy = de;
            return r;
        end
        mass = floor_sqrt(mass_sq);
        abs_e = (e < 0) ? -e : e;
        sum = abs_e + mass;
        dot = d[0] * p[0] + d[1] * p[1] + d[2] * p[2];
        kfac = dot + dew * sum;
        den = mass * sum;
        for (int i = 0; i < 3; i++) lab[i] = d[i] + round_div(p[i] * kfac, den);
        lab[3] = round_div(abs_e * dew + dot, mass);
        r.px = clamp_word(lab[0]);
        r.py = clamp_word(lab[1]);
        r.pz = clamp_word(lab[2]);
        r.energy = clamp_word(lab[3]);
        return r;
    endfunction

    assign o_fail_count = mismatches;
    assign o_pending = pending_count;

    always @(posedge i_clk) begin
        t_lab want;
        t_lab got;
        if (!i_rst_n) begin
            lab_queue.delete();
            mismatches <= 0;
            pending_count <= 0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                lab_queue.push_back(boost_to_lab(i_in.parent_px, i_in.parent_py,
                    i_in.parent_pz, i_in.parent_energy, i_in.daughter_px,
                    i_in.daughter_py, i_in.daughter_pz, i_in.daughter_energy));
            end
            if (i_out.valid && i_out.ready) begin
                got = {i_out.lab_px, i_out.lab_py, i_out.lab_pz, i_out.lab_energy,
                       i_out.bad_parent};
                if (lab_queue.size() == 0) begin
                    if (mismatches < 10)
                        $display("Unexpected result transaction: %h", got);
                    mismatches <= mismatches + 1;
                end else begin
                    want = lab_queue.pop_front();
                    if (want !== got) begin
                        if (mismatches < 10)
                            $display({"Mismatch: expected px %h py %h pz %h e %h bad %b,",
                                      " got px %h py %h pz %h e %h bad %b"},
                                want.px, want.py, want.pz, want.energy, want.bad,
                                got.px, got.py, got.pz, got.energy, got.bad);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            pending_count <= lab_queue.size();
        end
    end

endmodule

>>> verif/lorentz_boost_to_lab_unit_test.sv
// Testbench top that drives boost transactions into the unit and reports the verdict.
`timescale 1ns / 1ps

module lorentz_boost_to_lab_unit_test;

    localparam int WORD_BITS = 48;
    localparam int LATENCY = 200;

    typedef logic [WORD_BITS-1:0] t_word;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    logic calm_phase;
    logic hold_off;

    lbl_in_if  #(.WORD_BITS(WORD_BITS)) in_ch ();
    lbl_out_if #(.WORD_BITS(WORD_BITS)) out_ch ();

    lorentz_boost_to_lab_unit #(.WORD_BITS(WORD_BITS)) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    lorentz_boost_to_lab_unit_checker #(.WORD_BITS(WORD_BITS)) checker_inst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch.sink),
        .i_out       (out_ch.sink),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("TEST FAILED");
        $finish;
    end

    function automatic t_word random_word(int mode);
        t_word w;
        w = t_word'({$urandom, $urandom});
        case (mode)
            0: return w;
            1: return t_word'($signed(w[31:0]) >>> $urandom_range(0, 31));
            default: return t_word'($signed(w[WORD_BITS-1:0]) >>> $urandom_range(0, 47));
        endcase
    endfunction

    task automatic send_boost(t_word ppx, t_word ppy, t_word ppz, t_word pe,
                              t_word dpx, t_word dpy, t_word dpz, t_word de);
        while (!calm_phase && $urandom_range(0, 99) < 17) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.parent_px       <= ppx;
        in_ch.parent_py       <= ppy;
        in_ch.parent_pz       <= ppz;
        in_ch.parent_energy   <= pe;
        in_ch.daughter_px     <= dpx;
        in_ch.daughter_py     <= dpy;
        in_ch.daughter_pz     <= dpz;
        in_ch.daughter_energy <= de;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic send_physical();
        t_word ppx;
        t_word ppy;
        t_word ppz;
        t_word pe;
        t_word mag;
        int    sh;
        sh = $urandom_range(0, 22);
        ppx = t_word'($signed(random_word(0)) >>> (24 + sh));
        ppy = t_word'($signed(random_word(0)) >>> (24 + sh));
        ppz = t_word'($signed(random_word(0)) >>> (24 + sh));
        mag = t_word'(1) << (WORD_BITS - 2 - sh);
        pe = mag + random_word(0) % mag;
        if ($urandom_range(0, 1)) pe = -pe;
        send_boost(ppx, ppy, ppz, pe, random_word($urandom_range(0, 2)),
                   random_word($urandom_range(0, 2)), random_word($urandom_range(0, 2)),
                   random_word($urandom_range(0, 2)));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= !hold_off && (calm_phase || $urandom_range(0, 99) >= 17);
    end

    initial begin
        t_word maxw;
        t_word minw;
        maxw = {1'b0, {(WORD_BITS-1){1'b1}}};
        minw = {1'b1, {(WORD_BITS-1){1'b0}}};
        i_rst_n = 1'b0;
        calm_phase = 1'b0;
        hold_off = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.parent_px = '0;
        in_ch.parent_py = '0;
        in_ch.parent_pz = '0;
        in_ch.parent_energy = '0;
        in_ch.daughter_px = '0;
        in_ch.daughter_py = '0;
        in_ch.daughter_pz = '0;
        in_ch.daughter_energy = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Bad parents, a parent at rest with either sign of energy, extremes.
        send_boost('0, '0, '0, '0, maxw, minw, t_word'(1), t_word'(-1));
        send_boost(t_word'(1 << 24), '0, '0, t_word'(1 << 24),
                   t_word'(5), t_word'(6), t_word'(7), t_word'(8));
        send_boost(maxw, maxw, maxw, t_word'(1), t_word'(1), t_word'(1), t_word'(1),
                   t_word'(1));
        send_boost('0, '0, '0, t_word'(2 << 24), maxw, minw, '0, maxw);
        send_boost('0, '0, '0, t_word'(-(3 << 24)), minw, maxw, t_word'(-1), minw);
        send_boost('0, '0, '0, minw, t_word'(1), t_word'(2), t_word'(3), t_word'(4));
        send_boost('0, '0, '0, maxw, maxw, maxw, maxw, maxw);
        send_boost(t_word'(1), '0, '0, maxw, minw, minw, minw, minw);
        send_boost(t_word'(-1), t_word'(1), t_word'(-1), minw, maxw, maxw, maxw, maxw);
        send_boost(t_word'(3 << 24), t_word'(4 << 24), '0, t_word'(13 << 24),
                   t_word'(1 << 24), '0, '0, t_word'(12 << 24));
        send_boost(maxw >> 1, '0, '0, maxw, maxw, '0, '0, maxw);
        send_boost(minw >>> 1, '0, '0, minw, minw, '0, '0, minw);
        send_boost('0, '0, t_word'(1 << 30), t_word'(-(2 << 30)), '0, '0,
                   t_word'(-(1 << 24)), t_word'(1 << 24));
        send_boost(maxw, minw, '0, maxw, '0, '0, '0, '0);
        repeat (10) send_physical();

        // Long receiver hold-off while the sender keeps offering.
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge i_clk);
                hold_off = 1'b0;
            end
            repeat (300) send_physical();
        join
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);

        calm_phase = 1'b1;
        repeat (150) send_physical();
        calm_phase = 1'b0;
        for (int n = 0; n < 480; n++) begin
            if ($urandom_range(0, 4) == 0)
                send_boost(random_word($urandom_range(0, 2)), random_word($urandom_range(0, 2)),
                           random_word($urandom_range(0, 2)), random_word($urandom_range(0, 2)),
                           random_word(0), random_word(0), random_word(0), random_word(0));
            else
                send_physical();
        end
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> lorentz_boost_to_lab_unit.f
hdl/lbl_pkg.sv
hdl/lbl_if.sv
hdl/lbl_delay.sv
hdl/lbl_mul.sv
hdl/lbl_sqrt.sv
hdl/lbl_div.sv
hdl/lorentz_boost_to_lab_unit.sv
verif/lorentz_boost_to_lab_unit_checker.sv
verif/lorentz_boost_to_lab_unit_test.sv
